// ===== src/dmxt_pkg.sv =====
// Shared constants, codes and control/status types of the DMX512 frame transmitter.
package dmxt_pkg;

    // Slot store depth and the widths that follow from it.
    localparam int MAX_SLOTS = 513;
    localparam int ADDR_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // Fixed field widths.
    localparam int CAP_W  = 10;
    localparam int IDX_W  = 10;
    localparam int LEN_W  = 10;
    localparam int POS_W  = 10;
    localparam int BYTE_W = 8;
    // Wide enough for every count, capacity and position comparison.
    localparam int CMP_W  = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(513);
    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};

    // Item kinds.
    localparam logic [1:0] KIND_SLOT  = 2'd0;
    localparam logic [1:0] KIND_FLUSH = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    // Frame phases.
    localparam logic [1:0] PH_BREAK = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_IDLE  = 2'd3;

    // UART rate requests.
    localparam logic [1:0] RATE_KEEP  = 2'd0;
    localparam logic [1:0] RATE_BREAK = 2'd1;
    localparam logic [1:0] RATE_DATA  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic copy_start;
        logic copy_step;
        logic commit;
    } dmxt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic flush_go;
        logic copy_last;
        logic out_free;
    } dmxt_sts_t;

endpackage

// ===== src/dmxt_ctrl.sv =====
// Controller state machine of the DMX512 frame transmitter.
module dmxt_ctrl
    import dmxt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  dmxt_sts_t sts,
    output dmxt_cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // A flush with no frame in progress first copies the write store.
                if (sts.flush_go)
                begin
                    cmd.copy_start = 1'b1;
                    state_next     = ST_COPY;
                end
                else if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                if (sts.copy_last)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.copy_step = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ===== src/dmxt_dp.sv =====
// Datapath of the DMX512 frame transmitter: slot stores, frame state and result register.
module dmxt_dp
    import dmxt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic [1:0]        kind,
    input  logic [IDX_W-1:0]  slot_index,
    input  logic [BYTE_W-1:0] slot_data,
    input  logic [LEN_W-1:0]  frame_length,
    input  logic              tx_complete_flag,
    input  logic              data_empty_flag,
    input  dmxt_cmd_t         cmd,
    output dmxt_sts_t         sts,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              send_valid,
    output logic [BYTE_W-1:0] send_byte,
    output logic [1:0]        rate_change,
    output logic              complete_irq_enable,
    output logic              empty_irq_enable,
    output logic              clear_complete_flag,
    output logic              busy_res,
    output logic              frame_done
);

    // Configuration and the accepted beat.
    logic [CAP_W-1:0]  cap_reg;
    logic [1:0]        kind_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] dat_reg;
    logic [LEN_W-1:0]  len_in_reg;
    logic              txc_reg;
    logic              dre_reg;

    // Clear and copy sweep.
    logic [CNT_W-1:0]  cnt_reg;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [BYTE_W-1:0] ws_rd_reg;
    logic [BYTE_W-1:0] tx_rd_reg;

    // Frame state.
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic              busy_reg;
    logic              busy_next;
    logic              comp_reg;
    logic              comp_next;
    logic              empty_reg;
    logic              empty_next;

    // Result register.
    logic              out_valid_reg;
    logic              send_valid_reg;
    logic [BYTE_W-1:0] send_byte_reg;
    logic [1:0]        rate_reg;
    logic              clr_reg;
    logic              done_reg;
    logic              busy_out_reg;
    logic              comp_out_reg;
    logic              empty_out_reg;

    logic [BYTE_W-1:0] ws_mem [MAX_SLOTS];
    logic [BYTE_W-1:0] tx_mem [MAX_SLOTS];

    logic [CMP_W-1:0]  cap;
    logic              cnt_below_cap;
    logic              pos_in_store;
    logic [ADDR_W-1:0] cnt_addr;
    logic [ADDR_W-1:0] pos_addr;
    logic [BYTE_W-1:0] slot_byte;
    logic [POS_W-1:0]  pos_inc;
    logic              ws_slot_we;
    logic              o_send;
    logic [BYTE_W-1:0] o_byte;
    logic [1:0]        o_rate;
    logic              o_clr;
    logic              o_done;
    logic              out_free;

    // Capacity is used saturated to one through the store depth.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(MAX_SLOTS))
        begin
            cap = CMP_W'(MAX_SLOTS);
        end
        else
        begin
            cap = CMP_W'(cap_reg);
        end
    end

    assign cnt_below_cap = CMP_W'(cnt_reg) < cap;
    assign pos_in_store  = CMP_W'(pos_reg) < CMP_W'(MAX_SLOTS);
    assign cnt_addr      = ADDR_W'(cnt_reg);
    assign pos_addr      = pos_in_store ? ADDR_W'(pos_reg) : '0;
    assign slot_byte     = pos_in_store ? tx_rd_reg : '0;
    assign pos_inc       = (pos_reg != POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
    assign out_free      = !out_valid_reg || !out_stall;

    assign sts.clear_last = (cnt_reg == CNT_W'(MAX_SLOTS - 1));
    assign sts.flush_go   = (kind_reg == KIND_FLUSH) && !busy_reg;
    assign sts.copy_last  = !cnt_below_cap;
    assign sts.out_free   = out_free;

    // Step of the frame sequencer for the held beat.
    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        comp_next  = comp_reg;
        empty_next = empty_reg;
        ws_slot_we = 1'b0;
        o_send     = 1'b0;
        o_byte     = '0;
        o_rate     = RATE_KEEP;
        o_clr      = 1'b0;
        o_done     = 1'b0;
        case (kind_reg)
            KIND_SLOT:
            begin
                ws_slot_we = (CMP_W'(idx_reg) < cap);
            end
            KIND_FLUSH:
            begin
                if (!busy_reg)
                begin
                    busy_next  = 1'b1;
                    len_next   = (CMP_W'(len_in_reg) > cap) ? LEN_W'(cap) : len_in_reg;
                    o_rate     = RATE_BREAK;
                    phase_next = PH_START;
                    pos_next   = '0;
                    empty_next = 1'b0;
                    comp_next  = 1'b1;
                    o_send     = 1'b1;
                end
            end
            KIND_EVENT:
            begin
                if (busy_reg)
                begin
                    if (txc_reg)
                    begin
                        case (phase_reg)
                            PH_BREAK:
                            begin
                                o_rate     = RATE_BREAK;
                                phase_next = PH_START;
                                pos_next   = '0;
                                empty_next = 1'b0;
                                comp_next  = 1'b1;
                                o_send     = 1'b1;
                            end
                            PH_IDLE:
                            begin
                                o_clr      = 1'b1;
                                empty_next = 1'b0;
                                comp_next  = 1'b0;
                                phase_next = PH_BREAK;
                                busy_next  = 1'b0;
                                o_done     = 1'b1;
                            end
                            PH_START:
                            begin
                                o_rate     = RATE_DATA;
                                phase_next = PH_DATA;
                                comp_next  = 1'b0;
                                empty_next = 1'b1;
                                o_send     = 1'b1;
                                o_byte     = slot_byte;
                                pos_next   = pos_inc;
                            end
                            default:
                            begin
                                // Transmit-complete during the data phase changes nothing.
                            end
                        endcase
                    end
                    else if (dre_reg)
                    begin
                        if (pos_reg < len_reg)
                        begin
                            o_send   = 1'b1;
                            o_byte   = slot_byte;
                            pos_next = pos_inc;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            empty_next = 1'b0;
                            comp_next  = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Stores: one write port each, registered reads.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            ws_mem[cnt_addr] <= '0;
        end
        else if (cmd.commit && ws_slot_we)
        begin
            ws_mem[ADDR_W'(idx_reg)] <= dat_reg;
        end
        ws_rd_reg <= ws_mem[cnt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            tx_mem[wr_addr_reg] <= ws_rd_reg;
        end
        tx_rd_reg <= tx_mem[pos_addr];
    end

    // Beat capture and copy write address.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= kind;
            idx_reg    <= slot_index;
            dat_reg    <= slot_data;
            len_in_reg <= frame_length;
            txc_reg    <= tx_complete_flag;
            dre_reg    <= data_empty_flag;
        end
        wr_addr_reg <= cnt_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            cnt_reg     <= '0;
            wr_pend_reg <= 1'b0;
            pos_reg     <= '0;
            len_reg     <= '0;
            phase_reg   <= PH_BREAK;
            busy_reg    <= 1'b0;
            comp_reg    <= 1'b0;
            empty_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.copy_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clear_step || (cmd.copy_step && cnt_below_cap))
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            wr_pend_reg <= cmd.copy_step && cnt_below_cap;
            if (cmd.commit)
            begin
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                phase_reg <= phase_next;
                busy_reg  <= busy_next;
                comp_reg  <= comp_next;
                empty_reg <= empty_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            send_valid_reg <= o_send;
            send_byte_reg  <= o_byte;
            rate_reg       <= o_rate;
            clr_reg        <= o_clr;
            done_reg       <= o_done;
            busy_out_reg   <= busy_next;
            comp_out_reg   <= comp_next;
            empty_out_reg  <= empty_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign send_valid          = send_valid_reg;
    assign send_byte           = send_byte_reg;
    assign rate_change         = rate_reg;
    assign complete_irq_enable = comp_out_reg;
    assign empty_irq_enable    = empty_out_reg;
    assign clear_complete_flag = clr_reg;
    assign busy_res            = busy_out_reg;
    assign frame_done          = done_reg;

endmodule

// ===== src/dmx512_frame_transmitter_top.sv =====
// Top level of the DMX512 frame transmitter: controller plus datapath.
// A slot write, a UART event or a flush while busy is accepted, then executed and committed to
// the result register; no new input beat is taken until that commit, which waits on a stall.
// A starting flush copies capacity slots one per cycle before it commits its result, and the
// next input beat is taken only after that commit.
// Reset is asynchronous and active low; all 513 entries of the write store are then cleared.
module dmx512_frame_transmitter_top
    import dmxt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [IDX_W-1:0]  slot_index,
    input  logic [BYTE_W-1:0] slot_data,
    input  logic [LEN_W-1:0]  frame_length,
    input  logic              tx_complete_flag,
    input  logic              data_empty_flag,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              send_valid,
    output logic [BYTE_W-1:0] send_byte,
    output logic [1:0]        rate_change,
    output logic              complete_irq_enable,
    output logic              empty_irq_enable,
    output logic              clear_complete_flag,
    output logic              busy_res,
    output logic              frame_done
);

    // The controller sequences the clear sweep, beat acceptance, the snapshot
    // copy and the commit of each step; the datapath owns all stores and state.
    dmxt_cmd_t cmd;
    dmxt_sts_t sts;

    dmxt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The result register in the datapath lets a finished beat wait for the
    // consumer while the next input beat is accepted and started.
    dmxt_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .kind                (kind),
        .slot_index          (slot_index),
        .slot_data           (slot_data),
        .frame_length        (frame_length),
        .tx_complete_flag    (tx_complete_flag),
        .data_empty_flag     (data_empty_flag),
        .cmd                 (cmd),
        .sts                 (sts),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .send_valid          (send_valid),
        .send_byte           (send_byte),
        .rate_change         (rate_change),
        .complete_irq_enable (complete_irq_enable),
        .empty_irq_enable    (empty_irq_enable),
        .clear_complete_flag (clear_complete_flag),
        .busy_res            (busy_res),
        .frame_done          (frame_done)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the DMX512 frame transmitter top level.
`timescale 1ns / 1ps

module tb
    import dmxt_pkg::*;
();

    // The package names kinds 0 to 2 only; kind 3 is a beat that does nothing.
    localparam logic [1:0] KIND_NOP = 2'd3;

    // The slowest correct run stays far below this many cycles. That run covers the
    // clearing pass after reset and every flush copying a full store. The receiver can
    // hold back result beats with its stall patterns.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_BEATS   = 90;
    localparam int SETTLE_CYCLES = 16;
    localparam int CAP_PLANS     = 10;

    // One input beat, field for field as it appears on the ports.
    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  slot_index;
        logic [BYTE_W-1:0] slot_data;
        logic [LEN_W-1:0]  frame_length;
        logic              tx_complete_flag;
        logic              data_empty_flag;
    } frame_item_t;

    // One result beat: what the sequencer tells the UART after a step.
    typedef struct packed {
        logic              send_valid;
        logic [BYTE_W-1:0] send_byte;
        logic [1:0]        rate_change;
        logic              complete_irq_enable;
        logic              empty_irq_enable;
        logic              clear_complete_flag;
        logic              busy_res;
        logic              frame_done;
    } uart_step_t;

    typedef struct packed {
        frame_item_t item;
        logic        typed;
        uart_step_t  want;
    } directed_row_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    // Results that can be read straight off the behavior. Field order is send_valid,
    // send_byte, rate_change, complete irq, empty irq, clear flag, busy, frame done.
    localparam uart_step_t QUIET      = '{1'b0, 8'h00, RATE_KEEP,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam uart_step_t BREAK_SENT = '{1'b1, 8'h00, RATE_BREAK, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam uart_step_t HELD_START = '{1'b0, 8'h00, RATE_KEEP,  1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam uart_step_t FRAME_END  = '{1'b0, 8'h00, RATE_KEEP,  1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    // Directed opening at the reset capacity of 513. The first flush therefore fills every
    // entry of the transmit store. Rows with typed clear are checked against the predictor.
    localparam int DIRECTED_ROWS = 22;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // A UART event with no frame in progress is ignored.
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b1, 1'b1}, 1'b1, QUIET},
        // The unused kind, with every other field at its top value.
        '{'{KIND_NOP,   10'd1023, 8'hFF, 10'd1023, 1'b1, 1'b1}, 1'b1, QUIET},
        // Slot writes: the start code, the last slot, and one beyond capacity.
        '{'{KIND_SLOT,  10'd0,    8'hFF, 10'd0,    1'b0, 1'b0}, 1'b1, QUIET},
        '{'{KIND_SLOT,  10'd512,  8'hA5, 10'd0,    1'b0, 1'b0}, 1'b1, QUIET},
        '{'{KIND_SLOT,  10'd1023, 8'h5A, 10'd0,    1'b0, 1'b0}, 1'b1, QUIET},
        '{'{KIND_SLOT,  10'd1,    8'h00, 10'd0,    1'b0, 1'b0}, 1'b1, QUIET},
        '{'{KIND_SLOT,  10'd2,    8'h81, 10'd0,    1'b0, 1'b0}, 1'b1, QUIET},
        // A three slot frame opens with a break byte.
        '{'{KIND_FLUSH, 10'd0,    8'h00, 10'd3,    1'b0, 1'b0}, 1'b1, BREAK_SENT},
        // A flush while busy and an event without flags leave the frame alone.
        '{'{KIND_FLUSH, 10'd0,    8'h00, 10'd1023, 1'b0, 1'b0}, 1'b1, HELD_START},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b0, 1'b0}, 1'b1, HELD_START},
        // Data empty during the start phase already sends a slot.
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b0, 1'b1}, 1'b0, '0},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b1, 1'b0}, 1'b0, '0},
        // Transmit complete in the data phase wins over data empty and does nothing.
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b1, 1'b1}, 1'b0, '0},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b0, 1'b1}, 1'b0, '0},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b0, 1'b1}, 1'b0, '0},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b0, 1'b1}, 1'b0, '0},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b1, 1'b0}, 1'b1, FRAME_END},
        // A zero length frame still sends its start code.
        '{'{KIND_FLUSH, 10'd0,    8'h00, 10'd0,    1'b0, 1'b0}, 1'b1, BREAK_SENT},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b1, 1'b0}, 1'b0, '0},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b0, 1'b1}, 1'b0, '0},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b1, 1'b0}, 1'b1, FRAME_END},
        '{'{KIND_EVENT, 10'd0,    8'h00, 10'd0,    1'b1, 1'b0}, 1'b1, QUIET}
    };

    // Every input starts at a known value.
    logic              clk              = 1'b0;
    logic              rst_n            = 1'b0;
    logic              cfg_wr_en        = 1'b0;
    logic [CAP_W-1:0]  cfg_wr_data      = '0;
    logic              in_valid         = 1'b0;
    logic              in_stall;
    logic [1:0]        kind             = KIND_SLOT;
    logic [IDX_W-1:0]  slot_index       = '0;
    logic [BYTE_W-1:0] slot_data        = '0;
    logic [LEN_W-1:0]  frame_length     = '0;
    logic              tx_complete_flag = 1'b0;
    logic              data_empty_flag  = 1'b0;
    logic              out_valid;
    logic              out_stall        = 1'b0;
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic [1:0]        rate_change;
    logic              complete_irq_enable;
    logic              empty_irq_enable;
    logic              clear_complete_flag;
    logic              busy_res;
    logic              frame_done;

    // Predicted sequencer state, kept in step with every accepted input beat.
    logic [CAP_W-1:0]  cap_reg;
    logic [BYTE_W-1:0] write_image [MAX_SLOTS];
    logic [BYTE_W-1:0] frame_image [MAX_SLOTS];
    logic [POS_W-1:0]  slot_ptr;
    logic [LEN_W-1:0]  frame_len;
    logic [1:0]        seq_phase;
    logic              seq_busy;
    logic              tc_armed;
    logic              dre_armed;

    // UART steps predicted for accepted beats whose result beat has not come yet.
    uart_step_t pending_steps [$];

    int          error_count  = 0;
    int          result_count = 0;
    int          cycle_count  = 0;
    int          burst_left   = 0;
    int          stall_run    = 0;
    stall_mode_t stall_mode   = STALL_NONE;

    dmx512_frame_transmitter_top uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .kind                (kind),
        .slot_index          (slot_index),
        .slot_data           (slot_data),
        .frame_length        (frame_length),
        .tx_complete_flag    (tx_complete_flag),
        .data_empty_flag     (data_empty_flag),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .send_valid          (send_valid),
        .send_byte           (send_byte),
        .rate_change         (rate_change),
        .complete_irq_enable (complete_irq_enable),
        .empty_irq_enable    (empty_irq_enable),
        .clear_complete_flag (clear_complete_flag),
        .busy_res            (busy_res),
        .frame_done          (frame_done)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The register value is used clamped to 1..MAX_SLOTS.
    function automatic int unsigned usable_slots();
        if (cap_reg == '0)
            return 1;
        if (int'(cap_reg) > MAX_SLOTS)
            return MAX_SLOTS;
        return int'(cap_reg);
    endfunction

    // Reads the slot under the pointer and moves the pointer on, saturating at the top.
    function automatic logic [BYTE_W-1:0] fetch_slot();
        logic [BYTE_W-1:0] b;
        b = '0;
        if (int'(slot_ptr) < MAX_SLOTS)
            b = frame_image[slot_ptr];
        if (slot_ptr != POS_MAX)
            slot_ptr = slot_ptr + 1'b1;
        return b;
    endfunction

    // Break entry: a zero byte at break rate, waiting on transmit complete.
    task automatic start_break(inout uart_step_t res);
        res.rate_change = RATE_BREAK;
        res.send_valid  = 1'b1;
        res.send_byte   = '0;
        seq_phase       = PH_START;
        slot_ptr        = '0;
        dre_armed       = 1'b0;
        tc_armed        = 1'b1;
    endtask

    // Applies one input beat to the predicted state and gives the UART step it causes.
    task automatic advance_sequencer(input frame_item_t it, output uart_step_t res);
        int unsigned cap;
        cap = usable_slots();
        res = '0;
        case (it.kind)
            KIND_SLOT:
            begin
                if (int'(it.slot_index) < cap)
                    write_image[it.slot_index] = it.slot_data;
            end
            KIND_FLUSH:
            begin
                if (!seq_busy)
                begin
                    seq_busy = 1'b1;
                    for (int s = 0; s < cap; s++)
                        frame_image[s] = write_image[s];
                    frame_len = (int'(it.frame_length) > cap) ? LEN_W'(cap) : it.frame_length;
                    start_break(res);
                end
            end
            KIND_EVENT:
            begin
                if (seq_busy && it.tx_complete_flag)
                begin
                    case (seq_phase)
                        PH_BREAK:
                            start_break(res);
                        PH_START:
                        begin
                            res.rate_change = RATE_DATA;
                            res.send_valid  = 1'b1;
                            res.send_byte   = fetch_slot();
                            seq_phase       = PH_DATA;
                            tc_armed        = 1'b0;
                            dre_armed       = 1'b1;
                        end
                        PH_IDLE:
                        begin
                            res.clear_complete_flag = 1'b1;
                            res.frame_done          = 1'b1;
                            seq_phase               = PH_BREAK;
                            seq_busy                = 1'b0;
                            tc_armed                = 1'b0;
                            dre_armed               = 1'b0;
                        end
                        default:
                            ;
                    endcase
                end
                else if (seq_busy && it.data_empty_flag)
                begin
                    if (slot_ptr < frame_len)
                    begin
                        res.send_valid = 1'b1;
                        res.send_byte  = fetch_slot();
                    end
                    else
                    begin
                        seq_phase = PH_IDLE;
                        dre_armed = 1'b0;
                        tc_armed  = 1'b1;
                    end
                end
            end
            default:
                ;
        endcase
        res.complete_irq_enable = tc_armed;
        res.empty_irq_enable    = dre_armed;
        res.busy_res            = seq_busy;
    endtask

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns, result beat %0d: %s", $time, result_count, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s is %0h, should be %0h", name, got, want));
    endtask

    // Compares one accepted result beat, field by field, with the oldest prediction.
    task automatic check_step(input uart_step_t got);
        uart_step_t want;
        if (pending_steps.size() == 0)
        begin
            flag_error($sformatf("result beat %h arrived with nothing outstanding", got));
            return;
        end
        want = pending_steps.pop_front();
        compare_field("send_valid",          8'(got.send_valid),          8'(want.send_valid));
        compare_field("send_byte",           got.send_byte,               want.send_byte);
        compare_field("rate_change",         8'(got.rate_change),         8'(want.rate_change));
        compare_field("complete_irq_enable", 8'(got.complete_irq_enable),
                      8'(want.complete_irq_enable));
        compare_field("empty_irq_enable",    8'(got.empty_irq_enable),
                      8'(want.empty_irq_enable));
        compare_field("clear_complete_flag", 8'(got.clear_complete_flag),
                      8'(want.clear_complete_flag));
        compare_field("busy_res",            8'(got.busy_res),            8'(want.busy_res));
        compare_field("frame_done",          8'(got.frame_done),          8'(want.frame_done));
        result_count++;
    endtask

    // Sends one input beat. The sender works in bursts: at the start of each burst it
    // may drop valid for a random gap. Once a beat is up, it holds until accepted, and
    // the accepted beat goes through the predictor at that same edge.
    task automatic push_beat(input frame_item_t it, input logic typed,
                             input uart_step_t typed_want);
        uart_step_t predicted;
        int         gap;
        gap = 0;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid         <= 1'b1;
        kind             <= it.kind;
        slot_index       <= it.slot_index;
        slot_data        <= it.slot_data;
        frame_length     <= it.frame_length;
        tx_complete_flag <= it.tx_complete_flag;
        data_empty_flag  <= it.data_empty_flag;
        do
            @(posedge clk);
        while (in_stall);
        advance_sequencer(it, predicted);
        pending_steps.push_back(typed ? typed_want : predicted);
    endtask

    // Stops sending and waits until every predicted result beat has been seen. It then
    // lets the block settle, so any copy or clear pass has surely ended.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cap_reg = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Picks the next random beat from the predicted state, so most beats walk real
    // frames: a flush, transmit complete out of the start phase, data empty through
    // the slots, then transmit complete out of idle. About one beat in seven is
    // unshaped noise. Slot writes are mixed in, during frames too. The flag says whether
    // the beat counts toward the phase budget; beats the block only ignores do not.
    task automatic pick_item(output frame_item_t it, output logic counts);
        int unsigned cap;
        int unsigned roll;
        cap  = usable_slots();
        roll = $urandom_range(0, 99);
        it.kind             = 2'($urandom_range(0, 3));
        it.slot_index       = IDX_W'($urandom_range(0, 1023));
        it.slot_data        = BYTE_W'($urandom_range(0, 255));
        it.frame_length     = LEN_W'($urandom_range(0, 1023));
        it.tx_complete_flag = 1'($urandom_range(0, 1));
        it.data_empty_flag  = 1'($urandom_range(0, 1));
        counts = 1'b0;
        if (roll < 15)
        begin
            // Noise. A frame of hundreds of slots would eat the whole budget, so a
            // noise flush at large capacity asks for a short frame.
            if (it.kind == KIND_FLUSH && !seq_busy && cap > 40)
                it.frame_length = LEN_W'($urandom_range(0, 12));
        end
        else if (!seq_busy || $urandom_range(0, 4) == 0)
        begin
            if (!seq_busy && $urandom_range(0, 9) < 4)
            begin
                it.kind = KIND_FLUSH;
                if (cap <= 40)
                begin
                    // Small stores: lengths over capacity, exactly capacity, or below it.
                    case ($urandom_range(0, 3))
                        0:       ;
                        1:       it.frame_length = LEN_W'(cap);
                        default: it.frame_length = LEN_W'($urandom_range(0, cap));
                    endcase
                end
                else if ($urandom_range(0, 4) == 0)
                    it.frame_length = LEN_W'($urandom_range(0, 40));
                else
                    it.frame_length = LEN_W'($urandom_range(0, 12));
            end
            else
            begin
                it.kind = KIND_SLOT;
                if ($urandom_range(0, 6) != 0)
                    it.slot_index = IDX_W'($urandom_range(0, cap - 1));
            end
            counts = (it.kind == KIND_FLUSH) || (int'(it.slot_index) < cap);
        end
        else
        begin
            it.kind = KIND_EVENT;
            counts  = 1'b1;
            if (seq_phase == PH_DATA)
            begin
                // Now and then a transmit complete, which must not disturb the data phase.
                it.tx_complete_flag = ($urandom_range(0, 9) == 0);
                it.data_empty_flag  = 1'b1;
            end
            else
                it.tx_complete_flag = ($urandom_range(0, 4) != 0);
        end
    endtask

    // The receiver switches between stall patterns: none at all, a coin toss, a stall a
    // quarter of the time, and a stall three quarters of the time.
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_run  = $urandom_range(8, 60);
        end
        stall_run = stall_run - 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
            STALL_LIGHT: out_stall <= (stall_run % 4 == 0);
            default:     out_stall <= (stall_run % 4 != 0);
        endcase
    end

    // A result beat is taken at a rising edge with valid high and stall low.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_step({send_valid, send_byte, rate_change, complete_irq_enable,
                        empty_irq_enable, clear_complete_flag, busy_res, frame_done});
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        frame_item_t      it;
        logic             counts;
        int               counted;
        logic [CAP_W-1:0] cap_plan [CAP_PLANS];

        // Predicted state after reset.
        cap_reg   = CAP_RESET;
        slot_ptr  = '0;
        frame_len = '0;
        seq_phase = PH_BREAK;
        seq_busy  = 1'b0;
        tc_armed  = 1'b0;
        dre_armed = 1'b0;
        foreach (write_image[s])
        begin
            write_image[s] = '0;
            frame_image[s] = '0;
        end

        // Capacity settings: zero and all ones (clamped to 1 and 513), the smallest
        // stores, two middle sizes, exactly 513 and one above it, and two random ones.
        cap_plan[0] = 10'd0;
        cap_plan[1] = 10'd1023;
        cap_plan[2] = 10'd1;
        cap_plan[3] = 10'd2;
        cap_plan[4] = 10'd7;
        cap_plan[5] = 10'd32;
        cap_plan[6] = 10'd513;
        cap_plan[7] = 10'd514;
        cap_plan[8] = CAP_W'($urandom_range(3, 60));
        cap_plan[9] = CAP_W'($urandom_range(0, 1023));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The block stalls input while it clears the write store; push_beat waits it out.
        for (int r = 0; r < DIRECTED_ROWS; r++)
            push_beat(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].want);

        // Each phase first lets every outstanding result come home, then changes the
        // capacity. A frame may still be open across the change, and that is intended.
        for (int p = 0; p < CAP_PLANS; p++)
        begin
            drain_results();
            write_capacity(cap_plan[p]);
            counted = 0;
            while (counted < PHASE_BEATS)
            begin
                pick_item(it, counts);
                push_beat(it, 1'b0, QUIET);
                if (counts)
                    counted++;
            end
        end

        drain_results();
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
